### sv/cfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared constants, types and the output saturation function for the
// complex-input, real-tap FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

	// Sizing
	localparam int MAX_TAPS    = 64;
	localparam int SAMPLE_BITS = 16;

	// Fixed field widths of the channels
	localparam int SAMPLE_FIELD_W = 16;
	localparam int COEF_W         = 16;
	localparam int TAP_IDX_W      = 6;
	localparam int TAP_CNT_W      = 7;
	localparam int OUT_W          = 24;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 7;
	localparam int FRAC_BITS      = 15;

	// Derived widths
	localparam int IDX_W = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = SAMPLE_BITS + COEF_W + IDX_W;
	localparam int CMP_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
	localparam int TIX_CMP_W = ((TAP_IDX_W > CNT_W) ? TAP_IDX_W : CNT_W) + 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE = 2'd1;

	// Item modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_TAP  = 1'b1;

	// Output limits
	localparam logic signed [OUT_W-1:0] OUT_MAX_V = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN_V = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_FLUSH,
		ST_HOLD
	} cfir_state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} cfir_cplx_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} cfir_acc_t;

	// Controller to datapath
	typedef struct packed {
		logic             shift;
		logic             tap_we;
		logic [IDX_W-1:0] tap_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             inject;
		logic [IDX_W-1:0] head;
		logic             capture;
		logic             emit;
	} cfir_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic tok_exit;
		logic out_free;
	} cfir_sts_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] val;
		logic                    hit;
	} cfir_sat_t;

	// Floor shift by FRAC_BITS, then clamp to the output range
	function automatic cfir_sat_t sat_out(input logic signed [ACC_W-1:0] acc);
		logic signed [CMP_W-1:0] wide;
		logic signed [CMP_W-1:0] hi;
		logic signed [CMP_W-1:0] lo;
		cfir_sat_t r;
		wide = CMP_W'(acc) >>> FRAC_BITS;
		hi   = CMP_W'(OUT_MAX_V);
		lo   = CMP_W'(OUT_MIN_V);
		if (wide > hi) begin
			r.val = OUT_MAX_V;
			r.hit = 1'b1;
		end else if (wide < lo) begin
			r.val = OUT_MIN_V;
			r.hit = 1'b1;
		end else begin
			r.val = wide[OUT_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

### sv/cfir_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir channel interfaces
// Valid/ready channels for input items, filter results and register writes.
// ----------------------------------------------------------------------------
interface cfir_sample_if;
	logic                                          valid;
	logic                                          ready;
	logic                                          mode;
	logic signed [cfir_pkg::SAMPLE_FIELD_W-1:0]    sample_re;
	logic signed [cfir_pkg::SAMPLE_FIELD_W-1:0]    sample_im;
	logic        [cfir_pkg::TAP_IDX_W-1:0]         tap_index;
	logic signed [cfir_pkg::COEF_W-1:0]            tap_value;

	modport source (output valid, mode, sample_re, sample_im, tap_index, tap_value,
		input ready);
	modport sink (input valid, mode, sample_re, sample_im, tap_index, tap_value,
		output ready);
endinterface

interface cfir_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cfir_pkg::OUT_W-1:0]    out_re;
	logic signed [cfir_pkg::OUT_W-1:0]    out_im;
	logic                                 clipped;

	modport source (output valid, out_re, out_im, clipped, input ready);
	modport sink (input valid, out_re, out_im, clipped, output ready);
endinterface

interface cfir_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [cfir_pkg::CFG_IDX_W-1:0]       index;
	logic [cfir_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/cfir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/cfir_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_cell
// One delay-line cell: holds one complex history sample, passes it to the
// older neighbor on a push, and adds its product into the partial sum that
// walks through the chain toward the newest sample.
// ----------------------------------------------------------------------------
module cfir_cell (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      shift,
	input  cfir_pkg::cfir_cplx_t                      samp_in,
	output cfir_pkg::cfir_cplx_t                      samp_out,
	input  logic signed [cfir_pkg::COEF_W-1:0]        coef,
	input  logic                                      inject,
	input  logic                                      tok_in,
	input  cfir_pkg::cfir_acc_t                       acc_in,
	output cfir_pkg::cfir_acc_t                       acc_out,
	output logic                                      tok_out
);

	localparam int PROD_W = cfir_pkg::SAMPLE_BITS + cfir_pkg::COEF_W;

	cfir_pkg::cfir_cplx_t      hist_q;
	cfir_pkg::cfir_acc_t       acc_q;
	cfir_pkg::cfir_acc_t       base;
	cfir_pkg::cfir_acc_t       acc_d;
	logic                      tok_q;
	logic signed [PROD_W-1:0]  prod_re;
	logic signed [PROD_W-1:0]  prod_im;

	// history sample, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift) begin
			hist_q <= samp_in;
		end
	end

	// multiply-accumulate; a fresh sum starts at the head cell
	always_comb begin
		prod_re  = hist_q.re * coef;
		prod_im  = hist_q.im * coef;
		base     = inject ? '0 : acc_in;
		acc_d.re = base.re + cfir_pkg::ACC_W'(prod_re);
		acc_d.im = base.im + cfir_pkg::ACC_W'(prod_im);
	end

	always_ff @(posedge clk) begin
		if (inject || tok_in) begin
			acc_q <= acc_d;
		end
	end

	// token marks where the partial sum currently is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= inject || tok_in;
		end
	end

	assign samp_out = hist_q;
	assign acc_out  = acc_q;
	assign tok_out  = tok_q;

endmodule

### sv/cfir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfir_ctrl
// Configuration registers, warm-up counter and the sequencer that feeds
// coefficients to the cell chain and hands the result to the output stage.
// ----------------------------------------------------------------------------
module cfir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	cfir_sample_if.sink          sample,
	cfir_cfg_if.sink             cfg,
	input  cfir_pkg::cfir_sts_t  sts,
	output cfir_pkg::cfir_ctl_t  ctl
);

	cfir_pkg::cfir_state_t                  state_q, state_d;
	logic [cfir_pkg::IDX_W-1:0]             step_q, step_d;
	logic [cfir_pkg::CNT_W-1:0]             warm_q, warm_d;
	logic [cfir_pkg::TAP_CNT_W-1:0]         tap_count_q;
	logic                                   center_q;
	logic                                   inject_q;

	logic [cfir_pkg::CNT_W-1:0]             taps_n;
	logic [cfir_pkg::CNT_W-1:0]             delay;
	logic [cfir_pkg::CNT_W-1:0]             warm_nx;
	logic [cfir_pkg::IDX_W-1:0]             head;
	logic                                   held;
	logic                                   tap_ok;

	// configuration writes, taken whenever offered
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfir_pkg::TAP_CNT_W'(1);
			center_q    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == cfir_pkg::REG_TAP_COUNT) begin
				tap_count_q <= cfg.data[cfir_pkg::TAP_CNT_W-1:0];
			end else if (cfg.index == cfir_pkg::REG_CENTER_MODE) begin
				center_q <= cfg.data[0];
			end
		end
	end

	// taps in use, centering delay, warm-up
	always_comb begin
		if (tap_count_q == '0) begin
			taps_n = cfir_pkg::CNT_W'(1);
		end else if (int'(tap_count_q) > cfir_pkg::MAX_TAPS) begin
			taps_n = cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS);
		end else begin
			taps_n = cfir_pkg::CNT_W'(tap_count_q);
		end
		head    = cfir_pkg::IDX_W'(taps_n - 1'b1);
		delay   = taps_n - 1'b1 - (taps_n >> 1);
		warm_nx = (warm_q < cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS)) ? warm_q + 1'b1 : warm_q;
		held    = center_q && (warm_nx <= delay);
		tap_ok  = cfir_pkg::TIX_CMP_W'(sample.tap_index)
			< cfir_pkg::TIX_CMP_W'(cfir_pkg::MAX_TAPS);
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cfir_pkg::ST_IDLE;
			step_q   <= '0;
			warm_q   <= '0;
			inject_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			warm_q   <= warm_d;
			inject_q <= (state_q == cfir_pkg::ST_FEED) && (step_q == '0);
		end
	end

	// next state and control outputs
	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		warm_d       = warm_q;
		sample.ready = 1'b0;
		ctl          = '0;
		ctl.tap_addr = cfir_pkg::IDX_W'(sample.tap_index);
		ctl.rd_addr  = step_q;
		ctl.inject   = inject_q;
		ctl.head     = head;
		unique case (state_q)
			cfir_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					if (sample.mode == cfir_pkg::MODE_TAP) begin
						ctl.tap_we = tap_ok;
					end else begin
						ctl.shift = 1'b1;
						warm_d    = warm_nx;
						if (!held) begin
							state_d = cfir_pkg::ST_FEED;
							step_d  = '0;
						end
					end
				end
			end
			cfir_pkg::ST_FEED: begin
				// coefficient k reaches the cell holding the sample n-1-k pushes old
				ctl.rd_en = 1'b1;
				if (step_q == head) begin
					state_d = cfir_pkg::ST_FLUSH;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			cfir_pkg::ST_FLUSH: begin
				if (sts.tok_exit) begin
					ctl.capture = 1'b1;
					state_d     = cfir_pkg::ST_HOLD;
				end
			end
			cfir_pkg::ST_HOLD: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = cfir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfir_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### sv/complex_fir_real_taps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fir_real_taps
// FIR filter with complex samples and real Q1.15 taps, built as a chain of
// delay-line cells through which the partial sum walks one cell per cycle.
//
//   channel  role    payload
//   sample   sink    mode, sample_re, sample_im, tap_index, tap_value
//   result   source  out_re, out_im, clipped
//   cfg      sink    index, data (0: tap_count, 1: center_mode)
//
// A tap load or a withheld push keeps the sequencer idle. After a push that
// yields a result, no item is taken until the sum has walked cells n-1 down
// to 0 (n: taps in use) and the result is in the output register. Reset
// clears the delay line, all taps, warm-up count and center_mode; tap_count
// resets to 1. A finished result sits in the output register while new items
// are taken; if it is still there when the next is done, the sequencer waits.
// ----------------------------------------------------------------------------
module complex_fir_real_taps (
	input  logic            clk,
	input  logic            arst_n,
	cfir_sample_if.sink     sample,
	cfir_result_if.source   result,
	cfir_cfg_if.sink        cfg
);

	cfir_pkg::cfir_ctl_t                     ctl;
	cfir_pkg::cfir_sts_t                     sts;

	logic [cfir_pkg::COEF_W-1:0]             ram_rdata;
	logic [cfir_pkg::MAX_TAPS-1:0]           vld_q;
	logic                                    vld_s1;
	logic signed [cfir_pkg::COEF_W-1:0]      coef_bc;

	cfir_pkg::cfir_cplx_t                    new_samp;
	cfir_pkg::cfir_cplx_t                    hist [cfir_pkg::MAX_TAPS];
	cfir_pkg::cfir_acc_t                     acc  [cfir_pkg::MAX_TAPS];
	logic [cfir_pkg::MAX_TAPS-1:0]           tok;

	cfir_pkg::cfir_sat_t                     sat_re, sat_im;
	logic signed [cfir_pkg::OUT_W-1:0]       res_re_q, res_im_q;
	logic                                    res_clip_q;
	logic                                    out_valid_q;
	logic signed [cfir_pkg::OUT_W-1:0]       out_re_q, out_im_q;
	logic                                    out_clip_q;

	// sequencer
	cfir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg),
		.sts    (sts),
		.ctl    (ctl)
	);

	// coefficient store; entries never loaded read as zero
	cfir_ram #(
		.WIDTH (cfir_pkg::COEF_W),
		.DEPTH (cfir_pkg::MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (ctl.tap_we),
		.waddr (ctl.tap_addr),
		.wdata (sample.tap_value),
		.re    (ctl.rd_en),
		.raddr (ctl.rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctl.tap_we) begin
				vld_q[ctl.tap_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_s1 <= vld_q[ctl.rd_addr];
			end
		end
	end

	assign coef_bc = vld_s1 ? $signed(ram_rdata) : '0;

	// incoming sample at SAMPLE_BITS
	assign new_samp.re = cfir_pkg::SAMPLE_BITS'(sample.sample_re);
	assign new_samp.im = cfir_pkg::SAMPLE_BITS'(sample.sample_im);

	// cell chain: samples age toward higher index, the sum walks toward cell 0
	for (genvar j = 0; j < cfir_pkg::MAX_TAPS; j++) begin : g_cell
		cfir_pkg::cfir_cplx_t nb_samp;
		cfir_pkg::cfir_acc_t  nb_acc;
		logic                 nb_tok;
		logic                 inj;

		if (j == 0) begin : g_first
			assign nb_samp = new_samp;
		end else begin : g_inner
			assign nb_samp = hist[j-1];
		end

		if (j == cfir_pkg::MAX_TAPS - 1) begin : g_last
			assign nb_acc = '0;
			assign nb_tok = 1'b0;
		end else begin : g_body
			assign nb_acc = acc[j+1];
			assign nb_tok = tok[j+1];
		end

		assign inj = ctl.inject && (ctl.head == cfir_pkg::IDX_W'(j));

		cfir_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (ctl.shift),
			.samp_in  (nb_samp),
			.samp_out (hist[j]),
			.coef     (coef_bc),
			.inject   (inj),
			.tok_in   (nb_tok),
			.acc_in   (nb_acc),
			.acc_out  (acc[j]),
			.tok_out  (tok[j])
		);
	end

	// result scaling and hold register
	always_comb begin
		sat_re = cfir_pkg::sat_out(acc[0].re);
		sat_im = cfir_pkg::sat_out(acc[0].im);
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			res_re_q   <= sat_re.val;
			res_im_q   <= sat_im.val;
			res_clip_q <= sat_re.hit || sat_im.hit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_re_q   <= res_re_q;
			out_im_q   <= res_im_q;
			out_clip_q <= res_clip_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.out_re  = out_re_q;
	assign result.out_im  = out_im_q;
	assign result.clipped = out_clip_q;

	assign sts.tok_exit = tok[0];
	assign sts.out_free = !out_valid_q || result.ready;

	// checks
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one partial sum in the cell chain");

	a_no_shift_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok) |-> !ctl.shift)
		else $error("delay line shifted while a sum is in flight");

	a_token_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> !(|tok))
		else $error("partial sum still in chain after capture");

	a_accept_idle_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |-> !(|tok) && !ctl.inject)
		else $error("item transfer while the chain is busy");

endmodule
